// File: sv/four_level_page_walk_assert.svh
// Assertion helpers for the page walk checker.
`ifndef FOUR_LEVEL_PAGE_WALK_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALK_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PFW_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFW_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pfw_pkg.sv
package pfw_pkg;

  // Physical word store size and index width
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam int ROOT_W    = 15;
  localparam int PADDR_W   = 2;

  // Configuration register addresses
  localparam logic [PADDR_W-1:0] REG_PAGE_ROOT = 2'd0;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAULT = 2'd1,
    ST_WDONE = 2'd2,
    ST_WREJ  = 2'd3
  } status_t;

  // Walker sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_DATA
  } state_t;

  // Word store access from the walker
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [63:0]       wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } ram_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic        load;
    status_t     status;
    logic [63:0] phys;
  } result_t;

endpackage

// File: sv/pfw_ram.sv
module pfw_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/pfw_walk.sv
module pfw_walk (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [63:0]            address,
  input  logic [63:0]            write_data,
  input  logic                   out_block,
  input  logic [pfw_pkg::ROOT_W-1:0] page_root,
  input  logic [63:0]            rdata,
  output pfw_pkg::ram_req_t      ram_req,
  output pfw_pkg::result_t       res
);
  import pfw_pkg::*;

  state_t            state, state_next;
  logic [1:0]        level, level_next;
  logic [63:0]       base, base_next;
  logic [47:0]       vaddr, vaddr_next;
  logic              oor, oor_next;
  logic [MEM_AW-1:0] clr_idx, clr_idx_next;

  logic              accept;
  logic              wr_bad;
  logic [8:0]        idx;
  logic [63:0]       ea;
  logic              ea_oor;
  logic [63:0]       entry;

  assign in_stall = (state != S_IDLE) || out_block;
  assign accept   = in_valid && !in_stall;

  // write checks: alignment and range
  assign wr_bad = (address[2:0] != 3'd0) || (address[63:3] >= 61'(MEM_WORDS));

  // table index for the current level
  always_comb begin
    case (level)
      2'd0:    idx = vaddr[47:39];
      2'd1:    idx = vaddr[38:30];
      2'd2:    idx = vaddr[29:21];
      default: idx = vaddr[20:12];
    endcase
  end

  // shared address unit: entry address and range test
  assign ea     = base + {52'd0, idx, 3'd0};
  assign ea_oor = ea[63:3] >= 61'(MEM_WORDS);

  // out-of-range entries read as zero
  assign entry = oor ? 64'd0 : rdata;

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    level <= level_next;
    base  <= base_next;
    vaddr <= vaddr_next;
    oor   <= oor_next;
  end

  // sequencer
  always_comb begin
    state_next    = state;
    level_next    = level;
    base_next     = base;
    vaddr_next    = vaddr;
    oor_next      = oor;
    clr_idx_next  = clr_idx;
    ram_req       = '0;
    ram_req.raddr = ea[MEM_AW+2:3];
    res           = '0;
    res.status    = ST_OK;

    case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_idx;
        ram_req.wdata = 64'd0;
        clr_idx_next  = clr_idx + MEM_AW'(1);
        if (clr_idx == MEM_AW'(MEM_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (!mode) begin
            // memory write finishes in the accept cycle
            ram_req.we    = !wr_bad;
            ram_req.waddr = address[MEM_AW+2:3];
            ram_req.wdata = write_data;
            res.load      = 1'b1;
            res.status    = wr_bad ? ST_WREJ : ST_WDONE;
          end else begin
            level_next = 2'd0;
            base_next  = {49'd0, page_root[ROOT_W-1:3], 3'd0};
            vaddr_next = address[47:0];
            state_next = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        ram_req.re = 1'b1;
        oor_next   = ea_oor;
        state_next = S_DATA;
      end
      S_DATA: begin
        if (!entry[0]) begin
          res.load   = 1'b1;
          res.status = ST_FAULT;
          state_next = S_IDLE;
        end else if (level == 2'd3) begin
          // final base has zero low bits, so the offset just fills them
          res.load   = 1'b1;
          res.status = ST_OK;
          res.phys   = {entry[63:12], vaddr[11:0]};
          state_next = S_IDLE;
        end else begin
          base_next  = {entry[63:12], 12'd0};
          level_next = level + 2'd1;
          state_next = S_ADDR;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/four_level_page_walk.sv
// Four-level page table walk over a 4096-word physical store. A write item
// is accepted from idle and its result (write done or rejected) stands
// in the output register at the next cycle. For a translation, each table
// level first forms the entry address in the shared entry-address adder,
// then takes the registered read of the single store read port; a fault
// ends the walk early at the failing level. One item is in work at a time,
// and in_stall stays high while a result waits in the output register
// under out_stall. After reset the store is cleared one word per cycle,
// all 4096 words, with in_stall high; page_root can be written over the
// APB port during that pass.
module four_level_page_walk (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfw_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [63:0]                  address,
  input  logic [63:0]                  write_data,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [63:0]                  phys_address
);
  import pfw_pkg::*;

  logic [ROOT_W-1:0] page_root;
  logic              out_block;
  logic [63:0]       rdata;
  ram_req_t          ram_req;
  result_t           res;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_root <= '0;
    end else if (psel && penable && pwrite && paddr == REG_PAGE_ROOT) begin
      page_root <= pwdata[ROOT_W-1:0];
    end
  end

  assign prdata = (paddr == REG_PAGE_ROOT) ? {{(32 - ROOT_W){1'b0}}, page_root} : 32'd0;

  // walker sequencer with shared address unit
  assign out_block = out_valid && out_stall;

  pfw_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .out_block  (out_block),
    .page_root  (page_root),
    .rdata      (rdata),
    .ram_req    (ram_req),
    .res        (res)
  );

  // physical word store
  pfw_ram #(
    .DEPTH (MEM_WORDS),
    .WIDTH (64)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status       <= res.status;
      phys_address <= res.phys;
    end
  end

endmodule

// File: sv/pfw_check.sv
`include "four_level_page_walk_assert.svh"

module pfw_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [63:0] phys_address
);
  import pfw_pkg::*;

  // a stalled result stays offered
  `PFW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `PFW_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(status) && $stable(phys_address), "result changed while stalled")

  // only a translated result carries an address
  `PFW_ASSERT_SAME(a_phys_zero, clk, rst, out_valid && status != ST_OK, phys_address == 64'd0, "address on non-translated result")

  // a write transfer reports its status in the next cycle
  `PFW_ASSERT_NEXT(a_write_result, clk, rst, in_valid && !in_stall && !mode, out_valid && (status == ST_WDONE || status == ST_WREJ), "write result missing")

  // a translation cannot finish in the cycle after its transfer
  `PFW_ASSERT_NEXT(a_walk_latency, clk, rst, in_valid && !in_stall && mode, !out_valid && in_stall, "walk finished too early")

endmodule

bind four_level_page_walk pfw_check u_check (.*);

// File: test/four_level_page_walk_tb.sv
`timescale 1ns / 100ps

module four_level_page_walk_tb;
  import pfw_pkg::*;

  localparam int GAP_MAX     = 7;
  localparam int HOLD_AT     = 100;   // result count at which the sink holds off
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;    // longer than one walk from transfer to result
  localparam int ITEMS_PER_PHASE = 170;
  localparam int NUM_PHASES  = 5;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [63:0] address;
  logic [63:0] write_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [63:0] phys_address;

  bit          gaps_on;
  logic [14:0] cur_root;

  four_level_page_walk uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .address      (address),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .phys_address (phys_address)
  );

  typedef struct {
    status_t     st;
    logic [63:0] phys;
  } walk_result_t;

  // Shadow of the word store and root; predicts one result per transfer
  class page_walk_scoreboard;
    bit [63:0]    words [MEM_WORDS];
    logic [14:0]  root;
    walk_result_t pending_results [$];
    int           errors;

    function new();
      foreach (words[i]) words[i] = '0;
      root   = '0;
      errors = 0;
    endfunction

    function void set_root(logic [14:0] v);
      root = v;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // Entry read: anything past the store reads as zero
    function bit [63:0] read_entry(logic [63:0] byte_addr);
      if ((byte_addr >> 3) >= MEM_WORDS) return '0;
      return words[byte_addr >> 3];
    endfunction

    function walk_result_t walk_or_store(logic m, logic [63:0] a, logic [63:0] d);
      walk_result_t res;
      logic [63:0]  base;
      logic [63:0]  entry;
      logic [8:0]   idx;
      bit           present;
      res.phys = '0;
      if (m == 1'b0) begin
        if (a[2:0] != 3'b000 || (a >> 3) >= MEM_WORDS) begin
          res.st = ST_WREJ;
        end else begin
          words[a >> 3] = d;
          res.st = ST_WDONE;
        end
      end else begin
        base    = {49'b0, root[14:3], 3'b000};
        present = 1'b1;
        for (int lvl = 0; lvl < 4; lvl++) begin
          idx   = 9'(a >> (39 - 9 * lvl));
          entry = read_entry(base + 64'(idx) * 64'd8);
          if (entry[0] == 1'b0) begin
            present = 1'b0;
            break;
          end
          base = {entry[63:12], 12'h000};
        end
        if (present) begin
          res.st   = ST_OK;
          res.phys = base + {52'b0, a[11:0]};
        end else begin
          res.st = ST_FAULT;
        end
      end
      return res;
    endfunction

    function void note_item(logic m, logic [63:0] a, logic [63:0] d);
      pending_results.push_back(walk_or_store(m, a, d));
    endfunction

    function void check_result(logic [1:0] st, logic [63:0] pa);
      walk_result_t exp_res;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result: status %0d phys %h", st, pa));
        return;
      end
      exp_res = pending_results.pop_front();
      if (st !== exp_res.st)
        report($sformatf("status mismatch: expected %0d got %0d", exp_res.st, st));
      if (pa !== exp_res.phys)
        report($sformatf("phys_address mismatch: expected %h got %h", exp_res.phys, pa));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void leftover();
      while (pending_results.size() != 0) begin
        void'(pending_results.pop_front());
        report("expected result never arrived");
      end
    endfunction
  endclass

  page_walk_scoreboard sb = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Known values on every input from time zero
  initial begin
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    mode       <= 1'b0;
    address    <= '0;
    write_data <= '0;
    out_stall  <= 1'b0;
  end

  function automatic logic [63:0] make_va(logic [15:0] hi, logic [8:0] i1, logic [8:0] i2,
                                          logic [8:0] i3, logic [8:0] i4, logic [11:0] off);
    return {hi, i1, i2, i3, i4, off};
  endfunction

  // APB write of page_root; upper data bits are random and should be dropped
  task automatic write_page_root(logic [14:0] v);
    logic [31:0] junk;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_PAGE_ROOT;
    pwdata  <= {junk[31:15], v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_root = v;
    sb.set_root(v);
  endtask

  // One input transfer; returns at the accepting edge with nothing scheduled
  task automatic send_item(logic m, logic [63:0] a, logic [63:0] d);
    int gap;
    gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    address    <= a;
    write_data <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(m, a, d);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_item();
    int          r;
    int          idx;
    logic [63:0] a;
    logic [63:0] d;
    logic [14:0] tbase;
    r = $urandom_range(0, 99);
    d = {$urandom, $urandom};
    a = {$urandom, $urandom};
    if (r < 45) begin
      // table entry write, mostly low indices so walks go deep
      if ($urandom_range(0, 3) == 0) tbase = {cur_root[14:3], 3'b000};
      else tbase = 15'($urandom_range(0, 7)) << 12;
      if ($urandom_range(0, 3) == 0) idx = $urandom_range(0, 511);
      else idx = $urandom_range(0, 3);
      a = 64'(tbase) + 64'(idx) * 64'd8;
      r = $urandom_range(0, 99);
      if (r < 60) d = {49'b0, 3'($urandom_range(0, 7)), d[11:1], 1'b1};
      else if (r < 85) d[0] = 1'b1;
      else d[0] = 1'b0;
      send_item(1'b0, a, d);
    end else if (r < 55) begin
      // junk writes: mostly rejected
      if ($urandom_range(0, 1) == 0) a = {49'b0, a[14:0]};
      send_item(1'b0, a, d);
    end else begin
      if ($urandom_range(0, 4) != 0) begin
        a[47:39] = 9'($urandom_range(0, 3));
        a[38:30] = 9'($urandom_range(0, 3));
        a[29:21] = 9'($urandom_range(0, 3));
        a[20:12] = 9'($urandom_range(0, 3));
      end
      send_item(1'b1, a, d);
    end
  endtask

  // Result sink with random stalls and one long hold-off
  initial begin : result_sink
    int gap;
    int got;
    got = 0;
    forever begin
      if (got == HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (rst !== 1'b0 || out_valid !== 1'b1);
      sb.check_result(status, phys_address);
      got++;
    end
  end

  initial begin : stimulus
    logic [14:0] roots [NUM_PHASES];
    roots[0] = 15'h7FFF;
    roots[1] = 15'($urandom_range(0, 7)) << 12;
    roots[2] = (15'($urandom_range(0, 7)) << 12) | 15'($urandom_range(1, 7));
    roots[3] = 15'($urandom);
    roots[4] = 15'h0000;
    gaps_on  = 1'b1;
    cur_root = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // root write lands during the clearing pass
    write_page_root(15'h0000);

    // build a full walk: root[1] -> page 1, [2] -> page 2, [3] -> page 3, [4] -> leaf
    send_item(1'b0, 64'h0008, 64'h1003);
    send_item(1'b0, 64'h1010, 64'h2001);
    send_item(1'b0, 64'h2018, 64'h3FFF);
    send_item(1'b0, 64'h3020, 64'hFFFF_FFFF_FFFF_F001);
    // success with max leaf base and offset; upper virtual bits ignored
    send_item(1'b1, make_va(16'hFFFF, 9'd1, 9'd2, 9'd3, 9'd4, 12'hFFF), '1);
    send_item(1'b1, make_va(16'h0000, 9'd1, 9'd2, 9'd3, 9'd4, 12'h000), '0);
    // not-present entry at each level
    send_item(1'b1, make_va(16'h1234, 9'd0, 9'd2, 9'd3, 9'd4, 12'h123), '0);
    send_item(1'b1, make_va(16'h0000, 9'd1, 9'd0, 9'd3, 9'd4, 12'h456), '0);
    send_item(1'b1, make_va(16'h0000, 9'd1, 9'd2, 9'd0, 9'd4, 12'h789), '0);
    send_item(1'b1, make_va(16'h0000, 9'd1, 9'd2, 9'd3, 9'd0, 12'hABC), '0);
    // leaf with zero base
    send_item(1'b0, 64'h3028, 64'h0000_0000_0000_0001);
    send_item(1'b1, make_va(16'h8000, 9'd1, 9'd2, 9'd3, 9'd5, 12'hABC), '0);
    // next level just past the store, and a huge base: both read zero
    send_item(1'b0, 64'h0030, 64'h8001);
    send_item(1'b1, make_va(16'h0000, 9'd6, 9'd0, 9'd0, 9'd0, 12'h000), '0);
    send_item(1'b0, 64'h0038, 64'hFFFF_FFFF_FFFF_F001);
    send_item(1'b1, make_va(16'h0000, 9'd7, 9'd511, 9'd0, 9'd0, 12'h000), '0);
    // unaligned and out-of-range writes
    send_item(1'b0, 64'h0041, 64'hDEAD_BEEF_0000_0001);
    send_item(1'b0, 64'h0007, '1);
    send_item(1'b0, 64'h8000, '1);
    send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFF8, '1);
    send_item(1'b0, '1, '1);
    // last and first words of the store
    send_item(1'b0, 64'h7FF8, '1);
    send_item(1'b0, 64'h0000, '0);
    send_item(1'b1, '1, '1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      write_page_root(roots[p]);
      gaps_on = (p != 2);
      repeat (ITEMS_PER_PHASE) random_item();
    end

    drain_and_settle();
    sb.leftover();
    if (sb.errors == 0) begin
      $display("four_level_page_walk_tb: done, clean");
    end else begin
      $display("four_level_page_walk_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("four_level_page_walk_tb: done, errors");
    $finish;
  end

endmodule
